[hw/rtl/bstf_pkg.sv]
// Shared types and constants for the bitmap set/test/find core.
// No dependencies; imported by bstf_scan_unit and bitmap_set_test_find_core.
package bstf_pkg;

    localparam int LEN_W          = 9;    // width of the length register and of position
    localparam int IDX_W          = 8;    // width of the bit index field
    localparam int KIND_W         = 3;
    localparam int BIT_IDX_W      = 6;    // bit index inside a word, words of up to 64 bits
    localparam int DEF_MAX_BITS   = 256;
    localparam int DEF_WORD_BITS  = 64;
    localparam int LEN_RESET      = 256;

    typedef enum logic [KIND_W-1:0] {
        KIND_SET       = 3'd0,
        KIND_CLEAR     = 3'd1,
        KIND_TEST      = 3'd2,
        KIND_SET_ALL   = 3'd3,
        KIND_CLEAR_ALL = 3'd4,
        KIND_FIND_NEXT = 3'd5,
        KIND_FIND_LAST = 3'd6,
        KIND_EMPTY     = 3'd7
    } t_kind;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN
    } t_state;

    // Per-word findings of the scan unit.
    typedef struct packed {
        logic                 any;
        logic [BIT_IDX_W-1:0] first;
        logic [BIT_IDX_W-1:0] last;
    } t_word_hits;

endpackage

[hw/rtl/bstf_scan_unit.sv]
// Word-level mask builder and bit finder for the bitmap core.
// Depends on bstf_pkg.
module bstf_scan_unit #(
    parameter int WORD_BITS = bstf_pkg::DEF_WORD_BITS,
    parameter int BASE_W    = bstf_pkg::LEN_W + 1
) (
    input  logic [BASE_W-1:0]           i_base,
    input  logic [bstf_pkg::LEN_W-1:0]  i_lo,
    input  logic [bstf_pkg::LEN_W-1:0]  i_hi,
    output logic [WORD_BITS-1:0]        o_mask,
    input  logic [WORD_BITS-1:0]        i_data,
    input  logic [WORD_BITS-1:0]        i_mask,
    output bstf_pkg::t_word_hits        o_hits
);
    import bstf_pkg::*;

    localparam int TW = $clog2(WORD_BITS + 1);
    localparam logic [BASE_W-1:0] WB_EXT = BASE_W'(WORD_BITS);

    // Number of bits of this word that lie below a limit.
    function automatic logic [TW-1:0] clip(input logic [BASE_W-1:0] lim,
                                            input logic [BASE_W-1:0] base);
        logic [BASE_W-1:0] d;
        d = lim - base;
        if (lim <= base) begin
            return '0;
        end else if (d >= WB_EXT) begin
            return TW'(WORD_BITS);
        end
        return d[TW-1:0];
    endfunction

    logic [TW-1:0]        th_hi;
    logic [TW-1:0]        th_lo;
    logic [WORD_BITS-1:0] x;
    logic [WORD_BITS-1:0] xr;
    logic [WORD_BITS-1:0] oh_lo;
    logic [WORD_BITS-1:0] oh_hi;
    logic [BIT_IDX_W-1:0] first;
    logic [BIT_IDX_W-1:0] ridx;

    // Mask of bits b with lo <= base + b < hi.
    always_comb begin
        th_hi = clip(BASE_W'(i_hi), i_base);
        th_lo = clip(BASE_W'(i_lo), i_base);
        for (int i = 0; i < WORD_BITS; i++) begin
            o_mask[i] = (TW'(i) < th_hi) && !(TW'(i) < th_lo);
        end
    end

    // Isolate the lowest set bit, and the highest through a reversed copy.
    always_comb begin
        x = i_data & i_mask;
        for (int i = 0; i < WORD_BITS; i++) begin
            xr[i] = x[WORD_BITS-1-i];
        end
        oh_lo = x & (~x + WORD_BITS'(1));
        oh_hi = xr & (~xr + WORD_BITS'(1));
        first = '0;
        ridx  = '0;
        for (int i = 0; i < WORD_BITS; i++) begin
            if (oh_lo[i]) begin
                first = first | BIT_IDX_W'(i);
            end
            if (oh_hi[i]) begin
                ridx = ridx | BIT_IDX_W'(i);
            end
        end
        o_hits.any   = |x;
        o_hits.first = first;
        o_hits.last  = BIT_IDX_W'(WORD_BITS - 1) - ridx;
    end

endmodule

[hw/rtl/bitmap_set_test_find_core.sv]
// Bitmap set/test/find core: bit vector in a word memory, one operation per command.
// Sequence: the accepted command is captured, each word below the scan limit is read and
//   folded in (and written back for a write command), then the result is strobed; default size: 4 words.
// A new command is not taken while one is in flight (busy high); the single memory read port
//   reads one word a cycle.
// Reset: synchronous, active low; a clearing pass then zeroes the memory, one word a cycle,
//   with busy high. Results cannot be stalled by the receiver.
module bitmap_set_test_find_core #(
    parameter int MAX_BITS  = bstf_pkg::DEF_MAX_BITS,
    parameter int WORD_BITS = bstf_pkg::DEF_WORD_BITS
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // command transfer
    input  logic                         start,
    output logic                         busy,
    input  logic [bstf_pkg::KIND_W-1:0]  i_kind,
    input  logic [bstf_pkg::IDX_W-1:0]   i_bit_index,
    // length register write
    input  logic                         i_cfg_we,
    input  logic [bstf_pkg::LEN_W-1:0]   i_cfg_wdata,
    // result transfer
    output logic                         o_valid,
    output logic                         o_bit_value,
    output logic [bstf_pkg::LEN_W-1:0]   o_position,
    output logic                         o_is_empty
);
    import bstf_pkg::*;

    localparam int WORD_COUNT = (MAX_BITS + WORD_BITS - 1) / WORD_BITS;
    localparam int WIW        = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
    localparam int BASE_W     = LEN_W + 1;   // base of a word can run one word past the limit
    localparam int LEN_CAP_I  = (MAX_BITS < 511) ? MAX_BITS : 511;
    localparam int LEN_RST_I  = (MAX_BITS < LEN_RESET) ? MAX_BITS : LEN_RESET;
    localparam logic [LEN_W-1:0]  LEN_CAP   = LEN_W'(LEN_CAP_I);
    localparam logic [LEN_W-1:0]  LEN_RST   = LEN_W'(LEN_RST_I);
    localparam logic [BASE_W-1:0] WB_STEP   = BASE_W'(WORD_BITS);
    localparam logic [WIW-1:0]    LAST_WORD = WIW'(WORD_COUNT - 1);

    // ------------------------------------------------------------------
    // Length register, saturated to the store size on write
    // ------------------------------------------------------------------
    logic [LEN_W-1:0] r_bits_in_use;
    logic [LEN_W-1:0] n_bits_in_use;

    always_comb begin
        n_bits_in_use = r_bits_in_use;
        if (i_cfg_we) begin
            n_bits_in_use = (i_cfg_wdata > LEN_CAP) ? LEN_CAP : i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bits_in_use <= LEN_RST;
        end else begin
            r_bits_in_use <= n_bits_in_use;
        end
    end

    // ------------------------------------------------------------------
    // Control state
    // ------------------------------------------------------------------
    t_state r_state;
    t_state n_state;

    logic [WIW-1:0]    r_clr_word;
    t_kind             r_op;
    logic [LEN_W-1:0]  r_lo;
    logic [LEN_W-1:0]  r_hi;
    logic [BASE_W-1:0] r_rd_base;
    logic [WIW-1:0]    r_rd_word;
    logic              r_pv;          // read data of r_pr_word is on r_rdata
    logic [WIW-1:0]    r_pr_word;
    logic [BASE_W-1:0] r_pr_base;
    logic [WORD_BITS-1:0] r_mask;
    logic [WORD_BITS-1:0] r_rdata;
    logic              r_any;
    logic              r_found;
    logic [LEN_W-1:0]  r_pos;

    logic accept;
    logic rd_issue;
    logic finish;
    logic is_write_op;
    logic is_set_op;

    logic                 mem_we;
    logic [WIW-1:0]       mem_waddr;
    logic [WORD_BITS-1:0] mem_wdata;

    logic [WORD_BITS-1:0] issue_mask;
    t_word_hits           hits;

    logic [LEN_W-1:0] idx_ext;
    logic             idx_in_range;

    assign idx_ext      = LEN_W'(i_bit_index);
    assign idx_in_range = idx_ext < r_bits_in_use;

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                if (r_clr_word == LAST_WORD) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (start) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (finish) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // State outputs
    always_comb begin
        busy        = 1'b1;
        accept      = 1'b0;
        rd_issue    = 1'b0;
        finish      = 1'b0;
        case (r_state)
            ST_CLEAR: begin
                busy = 1'b1;
            end
            ST_IDLE: begin
                busy   = 1'b0;
                accept = start;
            end
            ST_SCAN: begin
                rd_issue = r_rd_base < BASE_W'(r_hi);
                finish   = !rd_issue && !r_pv;
            end
            default: busy = 1'b1;
        endcase
    end

    assign is_set_op   = (r_op == KIND_SET) || (r_op == KIND_SET_ALL);
    assign is_write_op = is_set_op || (r_op == KIND_CLEAR) || (r_op == KIND_CLEAR_ALL);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_CLEAR;
            r_clr_word <= '0;
            r_pv       <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pv    <= rd_issue;
            if (r_state == ST_CLEAR) begin
                r_clr_word <= r_clr_word + WIW'(1);
            end
        end
    end

    // ------------------------------------------------------------------
    // Command capture: set the scan window [lo, hi) and the default position
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op      <= t_kind'(i_kind);
            r_rd_base <= '0;
            r_rd_word <= '0;
            r_any     <= 1'b0;
            r_found   <= 1'b0;
            r_pos     <= '0;
            case (t_kind'(i_kind))
                KIND_SET, KIND_CLEAR, KIND_TEST: begin
                    // single cell; out of range leaves an empty window
                    r_lo <= idx_ext;
                    r_hi <= idx_in_range ? idx_ext + LEN_W'(1) : '0;
                end
                KIND_FIND_NEXT: begin
                    r_lo  <= idx_ext;
                    r_hi  <= idx_in_range ? r_bits_in_use : '0;
                    r_pos <= idx_in_range ? r_bits_in_use : idx_ext;
                end
                KIND_FIND_LAST: begin
                    r_lo  <= '0;
                    r_hi  <= r_bits_in_use;
                    r_pos <= r_bits_in_use;
                end
                default: begin
                    r_lo <= '0;
                    r_hi <= r_bits_in_use;
                end
            endcase
        end else begin
            // advance the read pointer one word a cycle
            if (rd_issue) begin
                r_rd_base <= r_rd_base + WB_STEP;
                r_rd_word <= r_rd_word + WIW'(1);
            end
            // fold the findings of the word now on the read data
            if (r_pv) begin
                r_any <= r_any | hits.any;
                if ((r_op == KIND_FIND_NEXT) && !r_found && hits.any) begin
                    r_found <= 1'b1;
                    r_pos   <= LEN_W'(r_pr_base + BASE_W'(hits.first));
                end
                if ((r_op == KIND_FIND_LAST) && hits.any) begin
                    r_pos <= LEN_W'(r_pr_base + BASE_W'(hits.last));
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Word memory: one read and one write a cycle, read data registered.
    // A word is written the cycle after its read while the next word is read,
    // so the two ports never meet on one entry within a command.
    // ------------------------------------------------------------------
    logic [WORD_BITS-1:0] mem [WORD_COUNT];

    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_pr_word;
        mem_wdata = is_set_op ? (r_rdata | r_mask) : (r_rdata & ~r_mask);
        if (r_state == ST_CLEAR) begin
            mem_we    = 1'b1;
            mem_waddr = r_clr_word;
            mem_wdata = '0;
        end else if (r_pv && is_write_op) begin
            mem_we = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (rd_issue) begin
            r_rdata <= mem[r_rd_word];
        end
    end

    // Hold the mask and position of the word in flight alongside its read.
    always_ff @(posedge i_clk) begin
        if (rd_issue) begin
            r_pr_word <= r_rd_word;
            r_pr_base <= r_rd_base;
            r_mask    <= issue_mask;
        end
    end

    bstf_scan_unit #(
        .WORD_BITS (WORD_BITS),
        .BASE_W    (BASE_W)
    ) u_scan (
        .i_base (r_rd_base),
        .i_lo   (r_lo),
        .i_hi   (r_hi),
        .o_mask (issue_mask),
        .i_data (r_rdata),
        .i_mask (r_mask),
        .o_hits (hits)
    );

    // ------------------------------------------------------------------
    // Result register: one-cycle strobe after the last word is folded in
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= finish;
        end
    end

    always_ff @(posedge i_clk) begin
        if (finish) begin
            o_bit_value <= (r_op == KIND_TEST) && r_any;
            o_is_empty  <= (r_op == KIND_EMPTY) && !r_any;
            o_position  <= r_pos;
        end
    end

endmodule

[hw/rtl/bstf_checker.sv]
// Port-level checks for bitmap_set_test_find_core, attached by bind.
// No package dependency; sees the top-level ports only.
module bstf_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       start,
    input logic       busy,
    input logic       o_valid,
    input logic       o_bit_value,
    input logic [8:0] o_position,
    input logic       o_is_empty
);

    // A transfer in makes the core busy on the next cycle.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("core not busy after command transfer");

    // A result only follows a busy cycle, and the core is free while showing it.
    a_valid_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ($past(busy) && !busy))
        else $error("result strobe without preceding work");

    // Strobes never come in adjacent cycles.
    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe longer than one cycle");

    // An empty answer carries no position and no tested bit.
    a_empty_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_is_empty) |-> ((o_position == 9'd0) && !o_bit_value))
        else $error("empty result with other fields set");

endmodule

bind bitmap_set_test_find_core bstf_checker u_bstf_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .start       (start),
    .busy        (busy),
    .o_valid     (o_valid),
    .o_bit_value (o_bit_value),
    .o_position  (o_position),
    .o_is_empty  (o_is_empty)
);
